[src/smrp_pkg.sv]
package smrp_pkg;

   localparam logic [2:0] REQ_READ_BYTE  = 3'd0;
   localparam logic [2:0] REQ_READ_WORD  = 3'd1;
   localparam logic [2:0] REQ_WRITE_BYTE = 3'd2;
   localparam logic [2:0] REQ_COLL_RMW   = 3'd3;
   localparam logic [2:0] REQ_VIDEO_RMW  = 3'd4;
   localparam logic [2:0] REQ_XOR        = 3'd5;

   localparam logic [5:0] BASE_TICKS     = 6'd5;
   localparam logic [2:0] FAST_TICKS_RST = 3'd4;
   localparam logic [3:0] NIBBLE_MASK    = 4'hf;

   // classified item as it travels from the front to the back
   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] address;
      logic [7:0]  value;
      logic [31:0] mask;
      logic        fault;
      logic [5:0]  cost;
   } smrp_item_type;

endpackage

[src/sprite_memory_rmw_port.sv]
// Memory port of a sprite engine onto a byte RAM of MEM_BYTES bytes (a power
// of two), held as four byte lanes so that an unaligned 32-bit word is one
// access. After reset the port clears the RAM, one row of four bytes a
// cycle, and busy stays high while it clears. An item is taken when start
// is high and busy is low; it goes into a two-entry queue, is read from the
// lane RAMs and has its response registered onto the rsp_ ports, where
// rsp_valid marks it for exactly one cycle. The receiver cannot stall the
// port; results must be taken as they come. The lane RAMs bound the rate: an
// item is read, then written back, before the next item is read. busy also
// rises while the queue is full. The user must write fast_cycle_ticks through
// csr_valid/csr_data only while the port is idle; the port does not enforce it.
module sprite_memory_rmw_port #(
   parameter int MEM_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_type,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_value,
   input  logic [31:0] req_mask,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic        rsp_data_valid,
   output logic        rsp_address_fault,
   output logic [5:0]  rsp_cycle_cost,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data
);
   import smrp_pkg::*;

   smrp_item_type head;
   logic          head_valid;
   logic          pop;
   logic          clearing;

   assign csr_ready = 1'b1;

   smrp_front #(
      .MEM_BYTES (MEM_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_type    (req_type),
      .req_address (req_address),
      .req_value   (req_value),
      .req_mask    (req_mask),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .clearing    (clearing),
      .pop         (pop),
      .head_valid  (head_valid),
      .head        (head)
   );

   smrp_back #(
      .MEM_BYTES (MEM_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop),
      .clearing          (clearing),
      .rsp_valid         (rsp_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_data_valid    (rsp_data_valid),
      .rsp_address_fault (rsp_address_fault),
      .rsp_cycle_cost    (rsp_cycle_cost)
   );

endmodule

[src/smrp_front.sv]
module smrp_front #(
   parameter int MEM_BYTES = 65536
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [2:0]             req_type,
   input  logic [15:0]            req_address,
   input  logic [7:0]             req_value,
   input  logic [31:0]            req_mask,
   input  logic                   csr_valid,
   input  logic [2:0]             csr_data,
   input  logic                   clearing,
   input  logic                   pop,
   output logic                   head_valid,
   output smrp_pkg::smrp_item_type head
);
   import smrp_pkg::*;

   localparam int DEPTH = 2;

   logic [2:0]    fast_ff, fast_in;
   smrp_item_type queue_ff [DEPTH];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic          push;
   logic          full;
   logic          word_op;
   smrp_item_type item;

   assign full = (count_ff == 2'(DEPTH));
   assign busy = full | clearing;
   assign push = start & ~busy;

   // classify: fault check and bus cost are settled at acceptance
   always_comb begin
      word_op      = (req_type == REQ_READ_WORD) || (req_type == REQ_COLL_RMW);
      item.kind    = req_type;
      item.address = req_address;
      item.value   = req_value;
      item.mask    = req_mask;
      item.fault   = word_op && ({1'b0, req_address} > 17'(MEM_BYTES - 4));
      case (req_type)
         REQ_READ_WORD:                 item.cost = BASE_TICKS + 6'd3 * {3'd0, fast_ff};
         REQ_COLL_RMW:                  item.cost = BASE_TICKS + 6'd7 * {3'd0, fast_ff};
         REQ_VIDEO_RMW, REQ_XOR:        item.cost = BASE_TICKS + {3'd0, fast_ff};
         default:                       item.cost = BASE_TICKS;
      endcase
   end

   always_comb begin
      fast_in   = csr_valid ? csr_data : fast_ff;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff   <= FAST_TICKS_RST;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         fast_ff   <= fast_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   assign head_valid = (count_ff != 2'd0);
   assign head       = queue_ff[rd_ptr_ff];

endmodule

[src/smrp_back.sv]
module smrp_back #(
   parameter int MEM_BYTES = 65536
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  smrp_pkg::smrp_item_type head,
   output logic                    pop,
   output logic                    clearing,
   output logic                    rsp_valid,
   output logic [31:0]             rsp_read_data,
   output logic                    rsp_data_valid,
   output logic                    rsp_address_fault,
   output logic [5:0]              rsp_cycle_cost
);
   import smrp_pkg::*;

   localparam int ADDR_W = $clog2(MEM_BYTES);
   localparam int ROW_W  = ADDR_W - 2;
   localparam int ROWS   = MEM_BYTES / 4;

   logic             clr_ff, clr_in;
   logic [ROW_W-1:0] clr_row_ff, clr_row_in;
   logic             exec_ff, exec_in;
   smrp_item_type    ent_ff;

   logic [7:0]  rd_data [4];
   logic [7:0]  old_word [4];
   logic [7:0]  new_word [4];
   logic [7:0]  new_byte;
   logic [7:0]  old_byte;
   logic [31:0] old_flat;
   logic [31:0] new_flat;
   logic [31:0] hit;
   logic [3:0]  best;
   logic [1:0]  ent_lane;
   logic [1:0]  head_lane;
   logic        byte_wr;
   logic        coll_wr;
   logic [31:0] data;
   logic        valid;

   logic        rsp_valid_ff;
   logic [31:0] data_ff;
   logic        dvalid_ff;
   logic        fault_ff;
   logic [5:0]  cost_ff;

   assign clearing  = clr_ff;
   // one item at a time: each item is read, then written back in the following cycle
   assign pop       = head_valid & ~clr_ff & ~exec_ff;
   assign head_lane = head.address[1:0];
   assign ent_lane  = ent_ff.address[1:0];

   always_comb begin
      clr_in     = clr_ff;
      clr_row_in = clr_row_ff;
      if (clr_ff) begin
         clr_row_in = clr_row_ff + ROW_W'(1);
         if (clr_row_ff == ROW_W'(ROWS - 1)) begin
            clr_in = 1'b0;
         end
      end
      exec_in = pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_row_ff   <= '0;
         exec_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         clr_row_ff   <= clr_row_in;
         exec_ff      <= exec_in;
         rsp_valid_ff <= exec_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ent_ff <= head;
      end
   end

   // merge and response
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         old_word[k] = rd_data[ent_lane + 2'(k)];
      end
      old_flat = {old_word[3], old_word[2], old_word[1], old_word[0]};
      new_flat = (old_flat & ~ent_ff.mask) | ({4{ent_ff.value}} & ent_ff.mask);
      for (int k = 0; k < 4; k++) begin
         new_word[k] = new_flat[8*k +: 8];
      end
      hit  = old_flat & ent_ff.mask;
      best = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if ((hit[4*i +: 4] & NIBBLE_MASK) > best) begin
            best = hit[4*i +: 4];
         end
      end

      old_byte = rd_data[ent_lane];
      case (ent_ff.kind)
         REQ_VIDEO_RMW: new_byte = (old_byte & ent_ff.mask[7:0]) | ent_ff.value;
         REQ_XOR:       new_byte = old_byte ^ ent_ff.value;
         default:       new_byte = ent_ff.value;
      endcase

      byte_wr = exec_ff && (ent_ff.kind inside {REQ_WRITE_BYTE, REQ_VIDEO_RMW, REQ_XOR});
      coll_wr = exec_ff && (ent_ff.kind == REQ_COLL_RMW) && !ent_ff.fault;

      data  = 32'd0;
      valid = 1'b0;
      case (ent_ff.kind)
         REQ_READ_BYTE: begin
            data  = {24'd0, old_byte};
            valid = 1'b1;
         end
         REQ_READ_WORD: begin
            if (!ent_ff.fault) begin
               data  = old_flat;
               valid = 1'b1;
            end
         end
         REQ_COLL_RMW: begin
            if (!ent_ff.fault) begin
               data  = {28'd0, best};
               valid = 1'b1;
            end
         end
         default: begin
            data  = 32'd0;
            valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (exec_ff) begin
         data_ff   <= data;
         dvalid_ff <= valid;
         fault_ff  <= ent_ff.fault;
         cost_ff   <= ent_ff.cost;
      end
   end

   // four byte lanes, lane n holds the bytes whose address ends in n
   for (genvar b = 0; b < 4; b++) begin : g_lane
      logic [7:0]       mem [ROWS];
      logic [7:0]       rd_ff;
      logic [ROW_W-1:0] rd_row;
      logic [ROW_W-1:0] ent_row;
      logic [ROW_W-1:0] wr_row;
      logic [7:0]       wr_data;
      logic [1:0]       off;
      logic             wr_en;

      // a word that starts past this lane wraps into the next row
      assign rd_row  = head.address[ADDR_W-1:2]
                       + {{(ROW_W-1){1'b0}}, (2'(b) < head_lane)};
      assign ent_row = ent_ff.address[ADDR_W-1:2]
                       + {{(ROW_W-1){1'b0}}, (2'(b) < ent_lane)};
      assign off     = 2'(b) - ent_lane;
      assign wr_en   = clr_ff | coll_wr | (byte_wr & (ent_lane == 2'(b)));
      assign wr_row  = clr_ff ? clr_row_ff : ent_row;
      assign wr_data = clr_ff ? 8'd0 : (coll_wr ? new_word[off] : new_byte);

      always_ff @(posedge clock) begin
         if (pop) begin
            rd_ff <= mem[rd_row];
         end
         if (wr_en) begin
            mem[wr_row] <= wr_data;
         end
      end

      assign rd_data[b] = rd_ff;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = data_ff;
   assign rsp_data_valid    = dvalid_ff;
   assign rsp_address_fault = fault_ff;
   assign rsp_cycle_cost    = cost_ff;

endmodule
